>>> hdl/edf_pkg.sv
// Shared types and constants for the EDF periodic task scheduler.
// No dependencies.
package edf_pkg;
  localparam int unsigned MaxTasksDef = 16;
  localparam int unsigned ReqW = 2;
  localparam int unsigned IdW = 4;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_STATS = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // Result item of one request.
  typedef struct packed {
    logic [15:0] jobs_released;
    logic [39:0] wait_total;
    logic [31:0] total_missed;
    logic [4:0]  misses_now;
    logic        job_finished;
    logic [3:0]  run_task;
    logic        run_valid;
  } result_t;
endpackage

>>> hdl/edf_table.sv
// Per-task state table: one read and one write port per cycle.
// Depends on edf_pkg.
module edf_table #(
  parameter int unsigned MaxTasks = edf_pkg::MaxTasksDef,
  localparam int unsigned AW = $clog2(MaxTasks)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wburst_i,
  input  logic [15:0]   wperiod_i,
  input  logic [15:0]   wjobs_i,
  input  logic [15:0]   wleft_i,
  input  logic [31:0]   wdl_i,
  input  logic [31:0]   wrel_i,
  input  logic [39:0]   wwait_i,
  input  logic [15:0]   wcnt_i,
  output logic [15:0]   rburst_o,
  output logic [15:0]   rperiod_o,
  output logic [15:0]   rjobs_o,
  output logic [15:0]   rleft_o,
  output logic [31:0]   rdl_o,
  output logic [31:0]   rrel_o,
  output logic [39:0]   rwait_o,
  output logic [15:0]   rcnt_o
);
  logic [15:0] burst_q [MaxTasks];
  logic [15:0] period_q [MaxTasks];
  logic [15:0] jobs_q [MaxTasks];
  logic [15:0] left_q [MaxTasks];
  logic [31:0] dl_q [MaxTasks];
  logic [31:0] rel_q [MaxTasks];
  logic [39:0] wait_q [MaxTasks];
  logic [15:0] cnt_q [MaxTasks];

  // Small register file; the zero-reset fields are cleared at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxTasks; k++) begin
        jobs_q[k] <= '0;
        left_q[k] <= '0;
        dl_q[k]   <= '0;
        rel_q[k]  <= '0;
        wait_q[k] <= '0;
        cnt_q[k]  <= '0;
      end
    end else if (we_i) begin
      jobs_q[waddr_i] <= wjobs_i;
      left_q[waddr_i] <= wleft_i;
      dl_q[waddr_i]   <= wdl_i;
      rel_q[waddr_i]  <= wrel_i;
      wait_q[waddr_i] <= wwait_i;
      cnt_q[waddr_i]  <= wcnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      burst_q[waddr_i]  <= wburst_i;
      period_q[waddr_i] <= wperiod_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rburst_o  <= burst_q[raddr_i];
    rperiod_o <= period_q[raddr_i];
    rjobs_o   <= jobs_q[raddr_i];
    rleft_o   <= left_q[raddr_i];
    rdl_o     <= dl_q[raddr_i];
    rrel_o    <= rel_q[raddr_i];
    rwait_o   <= wait_q[raddr_i];
    rcnt_o    <= cnt_q[raddr_i];
  end
endmodule

>>> hdl/edf_periodic_task_scheduler.sv
// Top level of the EDF periodic task scheduler: sequencer and shared datapath.
// Depends on edf_pkg and edf_table.
//
// One request is taken at a time. A load, statistics or unused request goes
// through a read state and then the output state, and a tick makes one pass
// over the entries in use (a read and an update state for each, none when no
// task is in use): the pass releases and drops jobs entry by entry while
// tracking the earliest deadline, and the chosen entry is then read and updated
// once. The single read port of the task table sets this pace. A result waits
// in an output register; a new request is taken meanwhile, and only the last
// step of that request holds until the previous result has gone.
module edf_periodic_task_scheduler #(
  parameter int unsigned MaxTasks = edf_pkg::MaxTasksDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: task_id[3:0], burst[19:4], period[35:20], job_count[51:36], zero pad
  input  logic [55:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: run_valid[0], run_task[4:1], job_finished[5], misses_now[10:6],
  // total_missed[42:11], wait_total[82:43], jobs_released[98:83], zero pad
  output logic [103:0] m_axis_tdata
);
  localparam int unsigned AW = $clog2(MaxTasks);
  localparam int unsigned CW = $clog2(MaxTasks + 1);
  localparam int unsigned IdW_L = edf_pkg::IdW;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_UPD, S_BRD, S_BUPD, S_OUT
  } state_e;

  state_e state_q;
  logic [4:0]  tcount_q;
  logic [31:0] time_q, miss_q;
  logic [1:0]  req_q;
  logic [IdW_L-1:0] id_q;
  logic [15:0] burst_q, period_q, jobs_q;
  logic [AW-1:0] idx_q;
  logic        found_q;
  logic [AW-1:0] best_q;
  logic [31:0] bslack_q;
  logic [4:0]  mnow_q;
  logic        fin_q;
  logic        out_v_q;
  edf_pkg::result_t res_q, res_d;

  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0] wburst, wperiod, wjobs, wleft, wcnt;
  logic [31:0] wdl, wrel;
  logic [39:0] wwait;
  logic [15:0] rburst, rperiod, rjobs, rleft, rcnt;
  logic [31:0] rdl, rrel;
  logic [39:0] rwait;

  logic [CW-1:0] n_use;
  logic          id_ok;
  logic [AW-1:0] id_idx;
  logic          out_free;
  assign n_use = (32'(tcount_q) > MaxTasks) ? CW'(MaxTasks) : CW'(tcount_q);
  assign id_ok = (32'(id_q) < MaxTasks);
  assign id_idx = AW'(id_q);
  assign out_free = !out_v_q || m_axis_tready;

  edf_table #(.MaxTasks(MaxTasks)) u_table (
    .clk_i, .rst_ni, .raddr_i(raddr), .we_i(we), .waddr_i(waddr),
    .wburst_i(wburst), .wperiod_i(wperiod), .wjobs_i(wjobs), .wleft_i(wleft),
    .wdl_i(wdl), .wrel_i(wrel), .wwait_i(wwait), .wcnt_i(wcnt),
    .rburst_o(rburst), .rperiod_o(rperiod), .rjobs_o(rjobs), .rleft_o(rleft),
    .rdl_o(rdl), .rrel_o(rrel), .rwait_o(rwait), .rcnt_o(rcnt)
  );

  // Per-entry tick update of the scan pass: release, then drop.
  logic        rel_now, pend_old, drop;
  logic [15:0] left_a, jobs_a, cnt_a, left_b;
  logic [31:0] dl_a, rel_a, slack;
  logic [39:0] wait_a, wait_b;
  logic [1:0]  miss_inc;
  always_comb begin
    rel_now  = (rjobs != 16'd0) && (rdl == time_q);
    pend_old = rel_now && (rleft != 16'd0);
    left_a = rel_now ? rburst : rleft;
    jobs_a = rel_now ? rjobs - 16'd1 : rjobs;
    cnt_a  = rel_now ? rcnt + 16'd1 : rcnt;
    dl_a   = rel_now ? time_q + {16'd0, rperiod} : rdl;
    rel_a  = rel_now ? time_q : rrel;
    wait_a = pend_old ? rwait + {24'd0, rperiod} : rwait;
    slack  = dl_a - time_q;
    drop   = (left_a != 16'd0) && ({16'd0, left_a} > slack);
    left_b = drop ? 16'd0 : left_a;
    wait_b = drop ? wait_a + {24'd0, rperiod} : wait_a;
    miss_inc = {1'b0, pend_old} + {1'b0, drop};
  end

  // Run step for the chosen entry.
  logic [15:0] left_r;
  logic        fin;
  logic [31:0] wdelta;
  always_comb begin
    left_r = rleft - 16'd1;
    fin    = (left_r == 16'd0);
    wdelta = time_q + 32'd1 - rrel - {16'd0, rburst};
  end

  always_comb begin
    raddr = idx_q;
    we = 1'b0; waddr = idx_q;
    wburst = rburst; wperiod = rperiod; wjobs = rjobs; wleft = rleft;
    wdl = rdl; wrel = rrel; wwait = rwait; wcnt = rcnt;
    unique case (state_q)
      S_IDLE, S_OUT: raddr = id_idx;
      S_RD: begin
        if (req_q == edf_pkg::REQ_LOAD && id_ok) begin
          we = 1'b1; waddr = id_idx;
          wburst = burst_q; wperiod = period_q; wjobs = jobs_q; wleft = '0;
          wdl = time_q; wrel = time_q; wwait = '0; wcnt = '0;
        end
        raddr = (req_q == edf_pkg::REQ_TICK) ? idx_q : id_idx;
      end
      S_UPD: begin
        we = 1'b1;
        wleft = left_b; wjobs = jobs_a; wcnt = cnt_a;
        wdl = dl_a; wrel = rel_a; wwait = wait_b;
      end
      S_BRD: raddr = best_q;
      S_BUPD: begin
        we = found_q; waddr = best_q; wleft = left_r;
        wwait = fin ? rwait + {8'd0, wdelta} : rwait;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d = '0;
    res_d.total_missed = miss_q;
    if (req_q == edf_pkg::REQ_TICK) begin
      res_d.misses_now = mnow_q;
      if (found_q) begin
        res_d.run_valid    = 1'b1;
        res_d.run_task     = IdW_L'(best_q);
        res_d.job_finished = fin_q;
      end
    end else if (req_q == edf_pkg::REQ_STATS && id_ok) begin
      res_d.wait_total    = rwait;
      res_d.jobs_released = rcnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tcount_q <= 5'd16;
      time_q   <= '0;
      miss_q   <= '0;
      out_v_q  <= 1'b0;
      res_q    <= '0;
      req_q    <= '0;
      id_q     <= '0;
      burst_q  <= '0;
      period_q <= '0;
      jobs_q   <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      best_q   <= '0;
      bslack_q <= '0;
      mnow_q   <= '0;
      fin_q    <= 1'b0;
    end else begin
      if (cfg_we_i) tcount_q <= cfg_wdata_i;
      if (state_q == S_OUT && out_free) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_q    <= s_axis_tuser;
            id_q     <= s_axis_tdata[3:0];
            burst_q  <= s_axis_tdata[19:4];
            period_q <= s_axis_tdata[35:20];
            jobs_q   <= s_axis_tdata[51:36];
            idx_q    <= '0;
            found_q  <= 1'b0;
            mnow_q   <= '0;
            fin_q    <= 1'b0;
            state_q  <= S_RD;
          end
        end
        S_RD: begin
          if (req_q == edf_pkg::REQ_TICK) begin
            state_q <= (n_use == '0) ? S_BRD : S_UPD;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_UPD: begin
          miss_q <= miss_q + {30'd0, miss_inc};
          if ({3'd0, mnow_q} + {6'd0, miss_inc} > 8'd31) mnow_q <= 5'd31;
          else mnow_q <= mnow_q + {3'd0, miss_inc};
          if (left_b != 16'd0 && (!found_q || slack < bslack_q)) begin
            found_q  <= 1'b1;
            best_q   <= idx_q;
            bslack_q <= slack;
          end
          if (CW'(idx_q) + CW'(1) >= n_use) begin
            state_q <= S_BRD;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_RD;
          end
        end
        S_BRD: state_q <= S_BUPD;
        S_BUPD: begin
          fin_q   <= found_q && fin;
          time_q  <= time_q + 32'd1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // Hold here until the previous result has left the output register.
          if (out_free) begin
            res_q   <= res_d;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, res_q};

`ifndef ASSERT_OFF
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_time_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUPD) |=> (time_q == $past(time_q) + 32'd1))
    else $error("time did not advance");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> m_axis_tvalid) else $error("result lost");
`endif
endmodule

>>> test/tb_edf_periodic_task_scheduler.sv
// Self-checking testbench for the EDF periodic task scheduler.
// Depends on edf_pkg and edf_periodic_task_scheduler; a scoreboard predicts each result.
module tb_edf_periodic_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumTasks = 16;

  class edf_scoreboard;
    int unsigned errors;
    edf_pkg::result_t pending_q[$];
    logic [4:0]  active_tasks;
    logic [31:0] now;
    logic [31:0] miss_total;
    logic [15:0] burst_len [NumTasks];
    logic [15:0] period_len[NumTasks];
    logic [15:0] jobs_to_go[NumTasks];
    logic [15:0] units_left[NumTasks];
    logic [31:0] deadline  [NumTasks];
    logic [31:0] released_t[NumTasks];
    logic [39:0] waited    [NumTasks];
    logic [15:0] job_tally [NumTasks];

    function new();
      errors = 0;
      active_tasks = 5'd16;
      now = '0;
      miss_total = '0;
      for (int i = 0; i < NumTasks; i++) begin
        burst_len[i] = '0; period_len[i] = '0; jobs_to_go[i] = '0; units_left[i] = '0;
        deadline[i] = '0; released_t[i] = '0; waited[i] = '0; job_tally[i] = '0;
      end
    endfunction

    task report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
      errors++;
    endtask

    function void count_miss(int i, ref int unsigned misses);
      miss_total++;
      misses++;
      waited[i] += 40'(period_len[i]);
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(edf_pkg::req_e req, logic [55:0] data);
      edf_pkg::result_t r;
      logic [3:0]  id;
      int unsigned n, misses, best;
      bit          found;
      logic [31:0] slack, best_slack;
      id = data[3:0];
      r = '0;
      n = (active_tasks > NumTasks) ? NumTasks : active_tasks;
      misses = 0; found = 0; best = 0; best_slack = '0;
      case (req)
        edf_pkg::REQ_LOAD: begin
          burst_len[id] = data[19:4];
          period_len[id] = data[35:20];
          jobs_to_go[id] = data[51:36];
          units_left[id] = '0;
          deadline[id] = now;
          released_t[id] = now;
          waited[id] = '0;
          job_tally[id] = '0;
        end
        edf_pkg::REQ_STATS: begin
          r.wait_total = waited[id];
          r.jobs_released = job_tally[id];
        end
        edf_pkg::REQ_TICK: begin
          for (int i = 0; i < n; i++)
            if (jobs_to_go[i] != 0 && deadline[i] == now) begin
              if (units_left[i] != 0) count_miss(i, misses);
              released_t[i] = now;
              units_left[i] = burst_len[i];
              deadline[i] = now + 32'(period_len[i]);
              jobs_to_go[i]--;
              job_tally[i]++;
            end
          for (int i = 0; i < n; i++)
            if (units_left[i] != 0 && 32'(units_left[i]) > deadline[i] - now) begin
              units_left[i] = '0;
              count_miss(i, misses);
            end
          for (int i = 0; i < n; i++)
            if (units_left[i] != 0) begin
              slack = deadline[i] - now;
              if (!found || slack < best_slack) begin
                found = 1; best = i; best_slack = slack;
              end
            end
          if (found) begin
            r.run_valid = 1'b1;
            r.run_task = 4'(best);
            units_left[best]--;
            if (units_left[best] == 0) begin
              r.job_finished = 1'b1;
              waited[best] += 40'(now + 32'd1 - released_t[best] - 32'(burst_len[best]));
            end
          end
          r.misses_now = (misses > 31) ? 5'd31 : 5'(misses);
          now++;
        end
        default: ;
      endcase
      r.total_missed = miss_total;
      pending_q.push_back(r);
    endfunction

    task check_result(logic [103:0] data);
      edf_pkg::result_t e;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", '0, 64'(data[42:0]));
        return;
      end
      e = pending_q.pop_front();
      if (e.run_valid != data[0]) report_mismatch("run_valid", e.run_valid, data[0]);
      if (e.run_task != data[4:1]) report_mismatch("run_task", e.run_task, data[4:1]);
      if (e.job_finished != data[5]) report_mismatch("job_finished", e.job_finished, data[5]);
      if (e.misses_now != data[10:6]) report_mismatch("misses_now", e.misses_now, data[10:6]);
      if (e.total_missed != data[42:11])
        report_mismatch("total_missed", e.total_missed, data[42:11]);
      if (e.wait_total != data[82:43]) report_mismatch("wait_total", e.wait_total, data[82:43]);
      if (e.jobs_released != data[98:83])
        report_mismatch("jobs_released", e.jobs_released, data[98:83]);
    endtask
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [4:0]    cfg_wdata_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [55:0]   s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = edf_pkg::REQ_NONE;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;

  edf_scoreboard sched_sb = new();
  bit            steady = 0;   // no idling on either side while set

  always #1 clk_i = ~clk_i;

  edf_periodic_task_scheduler dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(edf_pkg::req_e req, logic [3:0] id, logic [15:0] burst,
                              logic [15:0] period, logic [15:0] jobs);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {4'b0, jobs, period, burst, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sched_sb.note_request(req, s_axis_tdata);
  endtask

  // Waits for every outstanding result, lets the block settle, then writes the register.
  task automatic set_task_count(logic [4:0] value);
    @(negedge clk_i) s_axis_tvalid = 1'b0;
    wait (sched_sb.pending_q.size() == 0);
    repeat (40) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    sched_sb.active_tasks = value;
    @(negedge clk_i) cfg_we_i = 1'b0;
  endtask

  task automatic random_request(logic [4:0] tasks);
    int unsigned pick;
    logic [3:0]  id;
    logic [15:0] b, p, j;
    pick = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, tasks - 1));
    b = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    p = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    j = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    if (pick < 14) send_request(edf_pkg::REQ_LOAD, id, b, p, j);
    else if (pick < 84) send_request(edf_pkg::REQ_TICK, 4'($urandom), b, p, j);
    else if (pick < 97) send_request(edf_pkg::REQ_STATS, id, b, p, j);
    else send_request(edf_pkg::REQ_NONE, id, b, p, j);
  endtask

  // Result side: random back-pressure, sampled at the rising edge.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else begin
        hold = idle_len();
        m_axis_tready = (hold == 0);
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sched_sb.check_result(m_axis_tdata);

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [4:0] phase_counts[5];
    phase_counts = '{5'd16, 5'd1, 5'd5, 5'd16, 5'd9};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed part: field extremes, odd tasks and a tie between equal tasks.
    set_task_count(5'd16);
    send_request(edf_pkg::REQ_LOAD, 4'd0, 16'd1, 16'd1, 16'd3);       // burst equals period
    send_request(edf_pkg::REQ_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(edf_pkg::REQ_LOAD, 4'd1, 16'd0, 16'd4, 16'd2);       // zero burst
    send_request(edf_pkg::REQ_LOAD, 4'd2, 16'd5, 16'd3, 16'd2);       // burst above period
    send_request(edf_pkg::REQ_LOAD, 4'd3, 16'd2, 16'd0, 16'd1);       // zero period
    send_request(edf_pkg::REQ_LOAD, 4'd4, 16'd3, 16'd5, 16'd0);       // inactive task
    send_request(edf_pkg::REQ_LOAD, 4'd5, 16'd2, 16'd6, 16'd3);
    send_request(edf_pkg::REQ_LOAD, 4'd6, 16'd2, 16'd6, 16'd3);
    repeat (6) send_request(edf_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
    send_request(edf_pkg::REQ_LOAD, 4'd0, 16'd2, 16'd3, 16'd4);       // reload
    send_request(edf_pkg::REQ_NONE, 4'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (4) send_request(edf_pkg::REQ_TICK, 4'd0, 16'd0, 16'd0, 16'd0);
    send_request(edf_pkg::REQ_STATS, 4'd0, 16'd0, 16'd0, 16'd0);
    send_request(edf_pkg::REQ_STATS, 4'd2, 16'd0, 16'd0, 16'd0);
    send_request(edf_pkg::REQ_STATS, 4'd5, 16'd0, 16'd0, 16'd0);
    send_request(edf_pkg::REQ_STATS, 4'd15, 16'd0, 16'd0, 16'd0);

    // Random part in phases of different table sizes.
    foreach (phase_counts[k]) begin
      set_task_count(phase_counts[k]);
      steady = (k == 3);
      repeat (385) random_request(phase_counts[k]);
    end
    steady = 0;

    @(negedge clk_i) s_axis_tvalid = 1'b0;
    wait (sched_sb.pending_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (sched_sb.errors == 0 && sched_sb.pending_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
